>>> hw/rtl/chs_pkg.sv
// chs_pkg: shared types and constants of the chained hash set engine
// used by the request interface and the top level; no dependencies

package chs_pkg;

	localparam int BUCKETS    = 1024;
	localparam int POOL_NODES = 1024;
	localparam int NODE_COUNT = BUCKETS + POOL_NODES;

	localparam int KEY_BITS    = 31;
	localparam int SLOT_BITS   = 32;
	localparam int BUCKET_BITS = $clog2(BUCKETS);
	localparam int NODE_BITS   = $clog2(NODE_COUNT);
	localparam int FREE_BITS   = $clog2(NODE_COUNT + 1);
	localparam int CMD_BITS    = 2;

	// multiplicative hash; bucket is the low bits of the product (BUCKETS a power of two)
	localparam logic [SLOT_BITS-1:0] KNUTH_MUL = 32'd2654435761;
	localparam logic [SLOT_BITS-1:0] EMPTY_KEY = '1;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_NONE   = 2'd3
	} command_t;

	typedef struct packed {
		logic [SLOT_BITS-1:0] key;
		logic [NODE_BITS-1:0] link;
	} node_t;

	localparam int NODE_WIDTH = $bits(node_t);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_HASH,
		S_WALK,
		S_APPEND,
		S_SUCC,
		S_CLEAR,
		S_DONE
	} state_t;

endpackage

>>> hw/rtl/chs_req_if.sv
// chs_req_if: request channel (command and key) with valid/ready handshake
// depends on chs_pkg

interface chs_req_if import chs_pkg::*;;
	logic                valid;
	logic                ready;
	logic [CMD_BITS-1:0] command;
	logic [KEY_BITS-1:0] key;

	modport source (output valid, command, key, input ready);
	modport sink (input valid, command, key, output ready);
endinterface

>>> hw/rtl/chs_rsp_if.sv
// chs_rsp_if: result channel (success, pool_full) with valid/ready handshake
// no dependencies

interface chs_rsp_if;
	logic valid;
	logic ready;
	logic success;
	logic pool_full;

	modport source (output valid, success, pool_full, input ready);
	modport sink (input valid, success, pool_full, output ready);
endinterface

>>> hw/rtl/chs_ram.sv
// chs_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module chs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/chained_hash_set_engine_top.sv
// chained_hash_set_engine_top: hash set with chained buckets in one node ram
// depends on chs_pkg, chs_req_if, chs_rsp_if, chs_ram
//
//  channel | dir | fields               | beat
//  req     | in  | command[1:0], key    | valid & ready
//  rsp     | out | success, pool_full   | valid & ready
//
// one request at a time: accept, hash, one read of the node ram per chain node
// visited, then the result step; an append adds a tail relink step, and a remove
// that pulls up its successor adds a copy step and a clear step
// after reset all NODE_COUNT (2048) nodes of the node ram are swept to empty, req not ready
// the result sits in an output register; a stalled rsp holds the engine in its last step

module chained_hash_set_engine_top import chs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	chs_req_if.sink    req,
	chs_rsp_if.source  rsp
);

	state_t                state_q, state_d;
	command_t              cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [SLOT_BITS-1:0]  prod_q;
	logic [NODE_BITS-1:0]  cur_q, cur_d;
	logic [NODE_BITS-1:0]  nx_q, nx_d;
	logic [SLOT_BITS-1:0]  cur_key_q, cur_key_d;
	logic [FREE_BITS-1:0]  next_free_q, next_free_d;
	logic [NODE_BITS-1:0]  init_q, init_d;
	logic                  ok_q, ok_d, full_q, full_d;
	logic                  out_valid_q, out_success_q, out_full_q;
	logic                  out_load;
	logic                  accept;

	logic                  ram_we;
	logic [NODE_BITS-1:0]  ram_waddr, ram_raddr;
	node_t                 ram_wdata, rd_node;
	logic [NODE_WIDTH-1:0] ram_rdata;
	logic [SLOT_BITS-1:0]  key_ext;
	logic [NODE_BITS-1:0]  bucket;

	chs_ram #(
		.WIDTH(NODE_WIDTH),
		.DEPTH(NODE_COUNT)
	) u_node_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_node = node_t'(ram_rdata);
	assign key_ext = {1'b0, key_q};
	assign bucket  = NODE_BITS'(prod_q[BUCKET_BITS-1:0]);
	assign accept  = req.valid && req.ready;

	assign rsp.valid     = out_valid_q;
	assign rsp.success   = out_success_q;
	assign rsp.pool_full = out_full_q;

	always_comb begin
		state_d     = state_q;
		cur_d       = cur_q;
		nx_d        = nx_q;
		cur_key_d   = cur_key_q;
		next_free_d = next_free_q;
		init_d      = init_q;
		ok_d        = ok_q;
		full_d      = full_q;
		out_load    = 1'b0;
		req.ready   = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = cur_q;
		ram_wdata   = '{key: EMPTY_KEY, link: '0};
		ram_raddr   = cur_q;

		unique case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = init_q;
				init_d    = init_q + 1'b1;
				if (init_q == NODE_BITS'(NODE_COUNT - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					ok_d   = 1'b0;
					full_d = 1'b0;
					if (command_t'(req.command) == CMD_NONE) begin
						state_d = S_DONE;
					end else begin
						state_d = S_HASH;
					end
				end
			end
			S_HASH: begin
				ram_raddr = bucket;
				cur_d     = bucket;
				state_d   = S_WALK;
			end
			S_WALK: begin
				priority if (rd_node.key == key_ext) begin
					if (cmd_q == CMD_REMOVE) begin
						if (rd_node.link == '0) begin
							ram_we  = 1'b1;
							ok_d    = 1'b1;
							state_d = S_DONE;
						end else begin
							// pull the successor up into this node
							ram_raddr = rd_node.link;
							nx_d      = rd_node.link;
							state_d   = S_SUCC;
						end
					end else begin
						ok_d    = (cmd_q == CMD_SEARCH);
						state_d = S_DONE;
					end
				end else if (cmd_q == CMD_ADD && rd_node.key == EMPTY_KEY) begin
					ram_we    = 1'b1;
					ram_wdata = '{key: key_ext, link: '0};
					ok_d      = 1'b1;
					state_d   = S_DONE;
				end else if (rd_node.link != '0) begin
					ram_raddr = rd_node.link;
					cur_d     = rd_node.link;
				end else if (cmd_q == CMD_ADD) begin
					if (next_free_q >= FREE_BITS'(NODE_COUNT)) begin
						full_d  = 1'b1;
						state_d = S_DONE;
					end else begin
						// new pool node first, tail relink next cycle
						ram_we      = 1'b1;
						ram_waddr   = next_free_q[NODE_BITS-1:0];
						ram_wdata   = '{key: key_ext, link: '0};
						nx_d        = next_free_q[NODE_BITS-1:0];
						cur_key_d   = rd_node.key;
						next_free_d = next_free_q + 1'b1;
						ok_d        = 1'b1;
						state_d     = S_APPEND;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_APPEND: begin
				ram_we    = 1'b1;
				ram_wdata = '{key: cur_key_q, link: nx_q};
				state_d   = S_DONE;
			end
			S_SUCC: begin
				ram_we    = 1'b1;
				ram_wdata = rd_node;
				ok_d      = 1'b1;
				state_d   = S_CLEAR;
			end
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = nx_q;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_q      <= '0;
			next_free_q <= FREE_BITS'(BUCKETS);
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			init_q      <= init_d;
			next_free_q <= next_free_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= command_t'(req.command);
			key_q  <= req.key;
			prod_q <= SLOT_BITS'({1'b0, req.key} * KNUTH_MUL);
		end
		cur_q     <= cur_d;
		nx_q      <= nx_d;
		cur_key_q <= cur_key_d;
		ok_q      <= ok_d;
		full_q    <= full_d;
		if (out_load) begin
			out_success_q <= ok_q;
			out_full_q    <= full_q;
		end
	end

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= FREE_BITS'(NODE_COUNT))
		else $error("pool pointer beyond node store");

	a_free_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(next_free_q) |-> next_free_q == $past(next_free_q) + 1'b1)
		else $error("pool pointer moved by other than one");

	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.pool_full |-> !rsp.success)
		else $error("pool full reported with success");

	a_no_result_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INIT |-> !rsp.valid && !req.ready)
		else $error("traffic during clearing sweep");

	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request taken while another is in progress");

endmodule
